[rtl/tvu_pkg.sv]
// Package: shared widths, register indexes and control types for the upsampler.
package tvu_pkg;

   // item field widths
   localparam int POS_W    = 9;
   localparam int SAMPLE_W = 16;
   localparam int VALUE_W  = 24;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SIZE_W     = 5;
   localparam int GAIN_W     = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN    = 3'd6;

   localparam logic [SIZE_W-1:0] SIZE_RESET  = 5'd30;
   localparam logic [SIZE_W-1:0] RATIO_RESET = 5'd2;
   localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd887;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // axis divider: dividend (2i+h+1) << 16, divisor 2h
   localparam int N1_W    = 11;
   localparam int WT_W    = 16;
   localparam int DIV_W   = N1_W + WT_W;
   localparam int DIVSR_W = 6;
   localparam int LIM_W   = 12;

   // datapath widths of the blend and gain stages
   localparam int X_W   = 34;
   localparam int Y_W   = 50;
   localparam int BL_W  = 24;
   localparam int PH_W  = 44;
   localparam int PL_W  = 41;
   localparam int S_W   = 68;
   localparam int SL_W  = 32;
   localparam int HI_W  = 54;
   localparam int LO_W  = 48;
   localparam int T_W   = 86;
   localparam int RND_SH = 56;
   localparam int ACC_W = T_W - RND_SH;

   // per-stage control bits
   typedef struct packed {
      logic v;
      logic query;
      logic err;
   } ctl_type;

endpackage

[rtl/tvu_if.sv]
// Interfaces: request and response channels of the upsampler.
interface tvu_req_if;
   import tvu_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;
   logic [POS_W-1:0]    pos_z;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, mode, pos_x, pos_y, pos_z, sample, input ready);
   modport sink   (input valid, mode, pos_x, pos_y, pos_z, sample, output ready);
endinterface

interface tvu_rsp_if;
   import tvu_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] fine_value;
   logic               range_error;
   logic               saturated;

   modport source (output valid, fine_value, range_error, saturated, input ready);
   modport sink   (input valid, fine_value, range_error, saturated, output ready);
endinterface

[rtl/trilinear_volume_upsampler_top.sv]
// A query passes the intake register, 27 divider steps and 8 stages to its response.
// One item per cycle while no response is held; divider, banks and blend fully pipelined.
// The store is eight banks split by index parity, so all eight neighbors are read at once.
// Writes produce no response and use the same pipeline, so stores stay in item order.
// Reset (synchronous) clears pipeline valids and loads register defaults; store is
// left unwritten.
module trilinear_volume_upsampler_top #(
   parameter int COARSE_DIM = 32,
   parameter int MAX_RATIO  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tvu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tvu_pkg::CSR_DATA_W-1:0] csr_wdata,
   tvu_req_if.sink                        req_if,
   tvu_rsp_if.source                      rsp_if
);
   import tvu_pkg::*;

   localparam int CW         = $clog2(COARSE_DIM);
   localparam int HW         = CW - 1;
   localparam int BA_W       = 3 * HW;
   localparam int BANK_DEPTH = 1 << BA_W;
   localparam int SZ_MAX     = COARSE_DIM - 2;

   typedef struct packed {
      logic                           v;
      logic                           query;
      logic                           err;
      logic                           wen;
      logic [2:0]                     wbank;
      logic [BA_W-1:0]                waddr;
      logic [SAMPLE_W-1:0]            sample;
      logic [2:0][DIV_W-1:0]          num;
      logic [2:0][DIVSR_W-1:0]        rem;
      logic [2:0][DIVSR_W-1:0]        dvs;
   } div_type;

   typedef struct packed {
      logic                           v;
      logic                           query;
      logic                           err;
      logic                           wen;
      logic [2:0]                     wbank;
      logic [BA_W-1:0]                waddr;
      logic [SAMPLE_W-1:0]            sample;
      logic [7:0][BA_W-1:0]           raddr;
      logic [2:0]                     par;
      logic [2:0][WT_W-1:0]           w;
   } addr_type;

   // configuration registers
   logic [SIZE_W-1:0] size_ff  [3];
   logic [SIZE_W-1:0] ratio_ff [3];
   logic [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            size_ff[a]  <= SIZE_RESET;
            ratio_ff[a] <= RATIO_RESET;
         end
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_SIZE_X:  size_ff[0]  <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Y:  size_ff[1]  <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Z:  size_ff[2]  <= csr_wdata[SIZE_W-1:0];
            REG_RATIO_X: ratio_ff[0] <= csr_wdata[SIZE_W-1:0];
            REG_RATIO_Y: ratio_ff[1] <= csr_wdata[SIZE_W-1:0];
            REG_RATIO_Z: ratio_ff[2] <= csr_wdata[SIZE_W-1:0];
            REG_GAIN:    gain_ff     <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a response is held
   logic adv;
   logic o_v_ff;
   assign adv          = !o_v_ff || rsp_if.ready;
   assign req_if.ready = adv;

   // intake: clamp, range check, divider setup, write address
   div_type dv_ff [DIV_W+1];
   div_type dv_in [DIV_W+1];

   logic [POS_W-1:0]  pos   [3];
   logic [SIZE_W-1:0] h_cl  [3];
   logic [SIZE_W-1:0] s_cl  [3];
   logic [LIM_W-1:0]  lim   [3];
   logic [N1_W-1:0]   n1    [3];
   logic [2:0]        out_r;
   logic [2:0]        in_st;

   assign pos[0] = req_if.pos_x;
   assign pos[1] = req_if.pos_y;
   assign pos[2] = req_if.pos_z;

   always_comb begin
      logic [DIVSR_W:0] t;
      for (int a = 0; a < 3; a++) begin
         if (ratio_ff[a] < 5'd2) h_cl[a] = 5'd2;
         else if (int'(ratio_ff[a]) > MAX_RATIO) h_cl[a] = SIZE_W'(MAX_RATIO);
         else h_cl[a] = ratio_ff[a];
         if (size_ff[a] == '0) s_cl[a] = 5'd1;
         else if (int'(size_ff[a]) > SZ_MAX) s_cl[a] = SIZE_W'(SZ_MAX);
         else s_cl[a] = size_ff[a];
         lim[a]   = LIM_W'(s_cl[a]) * LIM_W'(h_cl[a]) + LIM_W'(1);
         out_r[a] = LIM_W'(pos[a]) > lim[a];
         n1[a]    = N1_W'({pos[a], 1'b0}) + N1_W'(h_cl[a]) - N1_W'(1);
         in_st[a] = int'(pos[a]) < COARSE_DIM;
      end
      dv_in[0].v      = req_if.valid;
      dv_in[0].query  = req_if.mode == MODE_QUERY;
      dv_in[0].err    = |out_r;
      dv_in[0].wen    = (req_if.mode == MODE_WRITE) && (&in_st);
      dv_in[0].wbank  = {pos[2][0], pos[1][0], pos[0][0]};
      dv_in[0].waddr  = {pos[2][CW-1:1], pos[1][CW-1:1], pos[0][CW-1:1]};
      dv_in[0].sample = req_if.sample;
      for (int a = 0; a < 3; a++) begin
         dv_in[0].num[a] = {n1[a], {WT_W{1'b0}}};
         dv_in[0].rem[a] = '0;
         dv_in[0].dvs[a] = {h_cl[a], 1'b0};
      end
      // restoring divider, one quotient bit per stage per axis
      for (int i = 1; i <= DIV_W; i++) begin
         dv_in[i] = dv_ff[i-1];
         for (int a = 0; a < 3; a++) begin
            t = {dv_ff[i-1].rem[a], dv_ff[i-1].num[a][DIV_W-1]};
            if (t >= {1'b0, dv_ff[i-1].dvs[a]}) begin
               dv_in[i].rem[a] = DIVSR_W'(t - {1'b0, dv_ff[i-1].dvs[a]});
               dv_in[i].num[a] = {dv_ff[i-1].num[a][DIV_W-2:0], 1'b1};
            end else begin
               dv_in[i].rem[a] = t[DIVSR_W-1:0];
               dv_in[i].num[a] = {dv_ff[i-1].num[a][DIV_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_W; i++) dv_ff[i].v <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i <= DIV_W; i++) dv_ff[i] <= dv_in[i];
      end
   end

   // base cell, weight and bank addresses
   addr_type a_ff, a_in;
   always_comb begin
      logic [WT_W-1:0]       low;
      logic [N1_W-1:0]       qb;
      logic [2:0][CW-1:0]    base;
      logic [CW-1:0]         crd;
      logic [2:0][HW-1:0]    idx;
      a_in.v      = dv_ff[DIV_W].v;
      a_in.query  = dv_ff[DIV_W].query;
      a_in.err    = dv_ff[DIV_W].err;
      a_in.wen    = dv_ff[DIV_W].wen;
      a_in.wbank  = dv_ff[DIV_W].wbank;
      a_in.waddr  = dv_ff[DIV_W].waddr;
      a_in.sample = dv_ff[DIV_W].sample;
      for (int a = 0; a < 3; a++) begin
         low = dv_ff[DIV_W].num[a][WT_W-1:0];
         qb  = dv_ff[DIV_W].num[a][DIV_W-1:WT_W];
         // weight of one wraps the quotient: step back and saturate
         if (low == '0) begin
            base[a]   = CW'(qb - N1_W'(1));
            a_in.w[a] = {WT_W{1'b1}};
         end else begin
            base[a]   = CW'(qb);
            a_in.w[a] = low;
         end
         a_in.par[a] = base[a][0];
      end
      for (int k = 0; k < 8; k++) begin
         for (int a = 0; a < 3; a++) begin
            crd    = (base[a][0] == k[a]) ? base[a] : base[a] + CW'(1);
            idx[a] = crd[CW-1:1];
         end
         a_in.raddr[k] = {idx[2], idx[1], idx[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) a_ff.v <= 1'b0;
      else if (adv) a_ff <= a_in;
   end

   // banked store: eight reads per item, plus one write for an in-store write
   logic [SAMPLE_W-1:0] mem [8][BANK_DEPTH];
   logic [SAMPLE_W-1:0] rdata_ff [8];
   ctl_type             b_ctl_ff;
   logic [2:0]          b_par_ff;
   logic [2:0][WT_W-1:0] b_w_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (a_ff.v && a_ff.wen) mem[a_ff.wbank][a_ff.waddr] <= a_ff.sample;
         for (int k = 0; k < 8; k++) rdata_ff[k] <= mem[k][a_ff.raddr[k]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff.v <= 1'b0;
      end else if (adv) begin
         b_ctl_ff <= '{v: a_ff.v, query: a_ff.query, err: a_ff.err};
         b_par_ff <= a_ff.par;
         b_w_ff   <= a_ff.w;
      end
   end

   // x blend of four corner pairs
   ctl_type              c_ctl_ff;
   logic [1:0][WT_W-1:0] c_w_ff;
   logic [X_W-1:0]       xb_ff [4];
   logic [X_W-1:0]       xb_in [4];
   always_comb begin
      logic [WT_W:0]         ax;
      logic signed [X_W-1:0] s0, s1, wa, wb;
      ax = 17'h10000 - {1'b0, b_w_ff[0]};
      wa = X_W'($signed({1'b0, ax}));
      wb = X_W'($signed({1'b0, b_w_ff[0]}));
      for (int j = 0; j < 4; j++) begin
         s0 = X_W'($signed(rdata_ff[{j[1:0], 1'b0} ^ b_par_ff]));
         s1 = X_W'($signed(rdata_ff[{j[1:0], 1'b1} ^ b_par_ff]));
         xb_in[j] = s0 * wa + s1 * wb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff.v <= 1'b0;
      end else if (adv) begin
         c_ctl_ff <= b_ctl_ff;
         c_w_ff   <= b_w_ff[2:1];
         for (int j = 0; j < 4; j++) xb_ff[j] <= xb_in[j];
      end
   end

   // y blend
   ctl_type        d_ctl_ff;
   logic [WT_W-1:0] d_wz_ff;
   logic [Y_W-1:0] yb_ff [2];
   logic [Y_W-1:0] yb_in [2];
   always_comb begin
      logic [WT_W:0]         ay;
      logic signed [Y_W-1:0] wa, wb;
      ay = 17'h10000 - {1'b0, c_w_ff[0]};
      wa = Y_W'($signed({1'b0, ay}));
      wb = Y_W'($signed({1'b0, c_w_ff[0]}));
      for (int j = 0; j < 2; j++) begin
         yb_in[j] = Y_W'($signed(xb_ff[2*j])) * wa + Y_W'($signed(xb_ff[2*j+1])) * wb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctl_ff.v <= 1'b0;
      end else if (adv) begin
         d_ctl_ff <= c_ctl_ff;
         d_wz_ff  <= c_w_ff[1];
         yb_ff[0] <= yb_in[0];
         yb_ff[1] <= yb_in[1];
      end
   end

   // z blend as high and low partial products
   ctl_type         e_ctl_ff;
   logic [PH_W-1:0] ph_ff, ph_in;
   logic [PL_W-1:0] pl_ff, pl_in;
   always_comb begin
      logic [WT_W:0]          az;
      logic signed [PH_W-1:0] hwa, hwb;
      logic [PL_W-1:0]        lwa, lwb;
      az  = 17'h10000 - {1'b0, d_wz_ff};
      hwa = PH_W'($signed({1'b0, az}));
      hwb = PH_W'($signed({1'b0, d_wz_ff}));
      lwa = PL_W'(az);
      lwb = PL_W'(d_wz_ff);
      ph_in = PH_W'($signed(yb_ff[0][Y_W-1:BL_W])) * hwa
            + PH_W'($signed(yb_ff[1][Y_W-1:BL_W])) * hwb;
      pl_in = PL_W'(yb_ff[0][BL_W-1:0]) * lwa + PL_W'(yb_ff[1][BL_W-1:0]) * lwb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctl_ff.v <= 1'b0;
      end else if (adv) begin
         e_ctl_ff <= d_ctl_ff;
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
      end
   end

   // exact blend sum
   ctl_type        f_ctl_ff;
   logic [S_W-1:0] s_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         f_ctl_ff.v <= 1'b0;
      end else if (adv) begin
         f_ctl_ff <= e_ctl_ff;
         s_ff     <= (S_W'($signed(ph_ff)) <<< BL_W) + S_W'($signed({1'b0, pl_ff}));
      end
   end

   // gain, split at bit 32
   ctl_type         g_ctl_ff;
   logic [HI_W-1:0] hi_ff;
   logic [LO_W-1:0] lo_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         g_ctl_ff.v <= 1'b0;
      end else if (adv) begin
         g_ctl_ff <= f_ctl_ff;
         hi_ff    <= HI_W'($signed(s_ff[S_W-1:SL_W])) * HI_W'($signed({1'b0, gain_ff}));
         lo_ff    <= LO_W'(s_ff[SL_W-1:0]) * LO_W'(gain_ff);
      end
   end

   // round half up, saturate, response register
   logic [T_W-1:0]   tot;
   logic [ACC_W-1:0] acc;
   logic             sat_hi, sat_lo;
   always_comb begin
      tot = (T_W'($signed(hi_ff)) <<< SL_W) + T_W'({1'b0, lo_ff}) + (T_W'(1) << (RND_SH - 1));
      acc = tot[T_W-1:RND_SH];
      sat_hi = !acc[ACC_W-1] && (|acc[ACC_W-2:VALUE_W-1]);
      sat_lo = acc[ACC_W-1] && !(&acc[ACC_W-2:VALUE_W-1]);
   end

   logic [VALUE_W-1:0] o_value_ff;
   logic               o_err_ff;
   logic               o_sat_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (adv) begin
         o_v_ff   <= g_ctl_ff.v && g_ctl_ff.query;
         o_err_ff <= g_ctl_ff.err;
         if (g_ctl_ff.err) begin
            o_value_ff <= '0;
            o_sat_ff   <= 1'b0;
         end else begin
            o_value_ff <= sat_hi ? {1'b0, {(VALUE_W-1){1'b1}}} :
                          sat_lo ? {1'b1, {(VALUE_W-1){1'b0}}} : acc[VALUE_W-1:0];
            o_sat_ff   <= sat_hi || sat_lo;
         end
      end
   end

   assign rsp_if.valid       = o_v_ff;
   assign rsp_if.fine_value  = o_value_ff;
   assign rsp_if.range_error = o_err_ff;
   assign rsp_if.saturated   = o_sat_ff;

endmodule

[verif/testbench.sv]
// Testbench: checks trilinear upsampling of the coarse volume against a cycle-free predictor.
`timescale 1ns / 100ps

module testbench;
   import tvu_pkg::*;

   typedef struct {
      logic                mode;
      logic [POS_W-1:0]    px;
      logic [POS_W-1:0]    py;
      logic [POS_W-1:0]    pz;
      logic [SAMPLE_W-1:0] sample;
   } voxel_item_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               err;
      logic               sat;
   } fine_result_type;

   localparam int DIM = 32;
   localparam int MAX_H = 16;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tvu_req_if req_bus ();
   tvu_rsp_if rsp_bus ();

   trilinear_volume_upsampler_top dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_if(req_bus), .rsp_if(rsp_bus)
   );

   // register copies, raw as written
   logic [SIZE_W-1:0] size_x, size_y, size_z;
   logic [SIZE_W-1:0] ratio_x, ratio_y, ratio_z;
   logic [GAIN_W-1:0] gain;

   // volume copy (updated on accepted writes) and generator-side fill map
   logic [SAMPLE_W-1:0] volume [0:DIM*DIM*DIM-1];
   bit                  filled [0:DIM*DIM*DIM-1];

   voxel_item_type  pending_items [$];
   fine_result_type expected_values [$];

   int  failures = 0;
   int  n_queries = 0, n_writes = 0, n_errs = 0, n_sats = 0;
   bit  no_idle = 0;
   bit  req_fired = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   int  cycle_count = 0;

   // clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int eff_size(logic [SIZE_W-1:0] n);
      if (n < 1) return 1;
      if (n > DIM - 2) return DIM - 2;
      return int'(n);
   endfunction

   function automatic int eff_ratio(logic [SIZE_W-1:0] h);
      if (h < 2) return 2;
      if (h > MAX_H) return MAX_H;
      return int'(h);
   endfunction

   function automatic int grid_limit(int axis);
      case (axis)
         0: return eff_size(size_x) * eff_ratio(ratio_x) + 1;
         1: return eff_size(size_y) * eff_ratio(ratio_y) + 1;
         default: return eff_size(size_z) * eff_ratio(ratio_z) + 1;
      endcase
   endfunction

   // base coarse array index and Q0.16 weight for one axis
   function automatic void axis_map(input int idx, input int h, output int base,
                                    output int wt);
      int i, a, i0, num;
      i = idx - 1;
      a = 2 * i - h;
      i0 = (a >= 0) ? a / (2 * h) : -((-a + 2 * h - 1) / (2 * h));
      num = (2 * i + 1) - (2 * i0 + 1) * h;
      if (num < 0) num = 0;
      wt = (num * 65536) / (2 * h);
      if (wt > 65535) wt = 65535;
      base = i0 + 1;
   endfunction

   function automatic int vaddr(int x, int y, int z);
      return (z * DIM + y) * DIM + x;
   endfunction

   function automatic bit outside_grid(voxel_item_type it);
      return it.px > grid_limit(0) || it.py > grid_limit(1) || it.pz > grid_limit(2);
   endfunction

   // expected result of one query against the current volume and registers
   function automatic fine_result_type upsample_voxel(voxel_item_type it);
      fine_result_type r;
      int bx, by, bz, wx, wy, wz;
      longint sum, fx, fy, fz;
      logic signed [95:0] s96, g96, prod;
      r.value = '0; r.err = 1'b0; r.sat = 1'b0;
      if (outside_grid(it)) begin
         r.err = 1'b1;
         return r;
      end
      axis_map(it.px, eff_ratio(ratio_x), bx, wx);
      axis_map(it.py, eff_ratio(ratio_y), by, wy);
      axis_map(it.pz, eff_ratio(ratio_z), bz, wz);
      sum = 0;
      for (int dz = 0; dz < 2; dz++)
         for (int dy = 0; dy < 2; dy++)
            for (int dx = 0; dx < 2; dx++) begin
               fx = dx ? wx : 65536 - wx;
               fy = dy ? wy : 65536 - wy;
               fz = dz ? wz : 65536 - wz;
               sum += longint'($signed(volume[vaddr(bx + dx, by + dy, bz + dz)]))
                      * fx * fy * fz;
            end
      s96 = 96'(sum);
      g96 = {80'd0, gain};
      prod = (s96 * g96 + (96'sd1 <<< 55)) >>> 56;
      if (prod > 96'sd8388607) begin
         prod = 96'sd8388607; r.sat = 1'b1;
      end else if (prod < -96'sd8388608) begin
         prod = -96'sd8388608; r.sat = 1'b1;
      end
      r.value = prod[VALUE_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // stimulus helpers
   task automatic add_write(int x, int y, int z, logic [SAMPLE_W-1:0] s);
      voxel_item_type it;
      it.mode = MODE_WRITE; it.px = POS_W'(x); it.py = POS_W'(y); it.pz = POS_W'(z);
      it.sample = s;
      pending_items.push_back(it);
      if (x < DIM && y < DIM && z < DIM) filled[vaddr(x, y, z)] = 1;
   endtask

   // queries inside the grid first fill any neighbor not yet written
   task automatic add_query(int x, int y, int z);
      voxel_item_type it;
      int bx, by, bz, wx, wy, wz;
      it.mode = MODE_QUERY; it.px = POS_W'(x); it.py = POS_W'(y); it.pz = POS_W'(z);
      it.sample = SAMPLE_W'($urandom);
      if (!outside_grid(it)) begin
         axis_map(x, eff_ratio(ratio_x), bx, wx);
         axis_map(y, eff_ratio(ratio_y), by, wy);
         axis_map(z, eff_ratio(ratio_z), bz, wz);
         for (int dz = 0; dz < 2; dz++)
            for (int dy = 0; dy < 2; dy++)
               for (int dx = 0; dx < 2; dx++)
                  if (!filled[vaddr(bx + dx, by + dy, bz + dz)])
                     add_write(bx + dx, by + dy, bz + dz, SAMPLE_W'($urandom));
      end
      pending_items.push_back(it);
   endtask

   task automatic fill_corner(logic [SAMPLE_W-1:0] s);
      for (int z = 0; z < 2; z++)
         for (int y = 0; y < 2; y++)
            for (int x = 0; x < 2; x++)
               add_write(x, y, z, s);
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_bus.valid || expected_values.size() > 0)
         @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= d;
      case (idx)
         REG_SIZE_X:  size_x = d[SIZE_W-1:0];
         REG_SIZE_Y:  size_y = d[SIZE_W-1:0];
         REG_SIZE_Z:  size_z = d[SIZE_W-1:0];
         REG_RATIO_X: ratio_x = d[SIZE_W-1:0];
         REG_RATIO_Y: ratio_y = d[SIZE_W-1:0];
         REG_RATIO_Z: ratio_z = d[SIZE_W-1:0];
         REG_GAIN:    gain = d;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // 5-bit registers get random upper bits, which the block drops
   task automatic set_config(int sx, int sy, int sz, int hx, int hy, int hz, int g);
      csr_write(REG_SIZE_X,  {11'($urandom_range(0, 2047)), 5'(sx)});
      csr_write(REG_SIZE_Y,  {11'($urandom_range(0, 2047)), 5'(sy)});
      csr_write(REG_SIZE_Z,  {11'($urandom_range(0, 2047)), 5'(sz)});
      csr_write(REG_RATIO_X, {11'($urandom_range(0, 2047)), 5'(hx)});
      csr_write(REG_RATIO_Y, {11'($urandom_range(0, 2047)), 5'(hy)});
      csr_write(REG_RATIO_Z, {11'($urandom_range(0, 2047)), 5'(hz)});
      csr_write(REG_GAIN, 16'(g));
   endtask

   task automatic random_items(int count);
      int r, ax, lim [3];
      int c [3];
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         for (int a = 0; a < 3; a++) lim[a] = grid_limit(a);
         if (r < 25) begin
            // write inside the used coarse box, or anywhere
            if (r < 20)
               add_write($urandom_range(0, eff_size(size_x) + 1),
                         $urandom_range(0, eff_size(size_y) + 1),
                         $urandom_range(0, eff_size(size_z) + 1), SAMPLE_W'($urandom));
            else
               add_write($urandom_range(0, 481), $urandom_range(0, 481),
                         $urandom_range(0, 481), SAMPLE_W'($urandom));
         end else begin
            for (int a = 0; a < 3; a++) c[a] = $urandom_range(0, lim[a]);
            if (r >= 90) begin
               ax = $urandom_range(0, 2);
               if (lim[ax] < 481) c[ax] = $urandom_range(lim[ax] + 1, 481);
            end
            add_query(c[0], c[1], c[2]);
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin
      voxel_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fired) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_bus.valid  <= 1'b1;
            req_bus.mode   <= it.mode;
            req_bus.pos_x  <= it.px;
            req_bus.pos_y  <= it.py;
            req_bus.pos_z  <= it.pz;
            req_bus.sample <= it.sample;
            req_gap <= pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off while many items wait
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && cycle_count > 100 && pending_items.size() > 40) begin
         hold_done <= 1'b1;
         hold_left <= 300;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_gap <= pick_gap();
      end
   end

   // accepted items: update volume, predict query results
   always @(posedge clock) begin
      voxel_item_type it;
      req_fired = req_bus.valid && req_bus.ready && !reset;
      if (req_fired) begin
         it.mode = req_bus.mode; it.px = req_bus.pos_x; it.py = req_bus.pos_y;
         it.pz = req_bus.pos_z; it.sample = req_bus.sample;
         if (it.mode == MODE_WRITE) begin
            n_writes++;
            if (it.px < DIM && it.py < DIM && it.pz < DIM)
               volume[vaddr(it.px, it.py, it.pz)] = it.sample;
         end else begin
            n_queries++;
            expected_values.push_back(upsample_voxel(it));
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      fine_result_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_values.size() == 0) begin
            failures++;
            $display("%0t: unexpected result value=%h err=%b sat=%b", $time,
                     rsp_bus.fine_value, rsp_bus.range_error, rsp_bus.saturated);
         end else begin
            e = expected_values.pop_front();
            n_errs += e.err;
            n_sats += e.sat;
            if (rsp_bus.fine_value !== e.value || rsp_bus.range_error !== e.err ||
                rsp_bus.saturated !== e.sat) begin
               failures++;
               $display("%0t: mismatch expected value=%h err=%b sat=%b, got value=%h err=%b sat=%b",
                        $time, e.value, e.err, e.sat,
                        rsp_bus.fine_value, rsp_bus.range_error, rsp_bus.saturated);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_bus.valid = 1'b0; req_bus.mode = MODE_WRITE;
      req_bus.pos_x = '0; req_bus.pos_y = '0; req_bus.pos_z = '0; req_bus.sample = '0;
      rsp_bus.ready = 1'b0;
      size_x = SIZE_RESET; size_y = SIZE_RESET; size_z = SIZE_RESET;
      ratio_x = RATIO_RESET; ratio_y = RATIO_RESET; ratio_z = RATIO_RESET;
      gain = GAIN_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset registers, grid corners, out-of-grid and out-of-store
      no_idle = 1;
      add_query(0, 0, 0);
      add_query(61, 61, 61);
      add_query(1, 60, 30);
      add_query(62, 0, 0);
      add_query(0, 62, 0);
      add_query(0, 0, 481);
      add_write(32, 0, 0, 16'h1234);
      add_write(0, 481, 511 - 30, 16'h5678);
      wait_idle();

      // directed: full-scale samples at maximum gain, zero gain, unit gain
      set_config(2, 2, 2, 3, 3, 3, 16'hFFFF);
      fill_corner(16'h7FFF);
      add_query(0, 0, 0);
      fill_corner(16'h8000);
      add_query(1, 1, 1);
      wait_idle();
      set_config(2, 2, 2, 3, 3, 3, 0);
      add_query(0, 0, 0);
      wait_idle();
      set_config(2, 2, 2, 3, 3, 3, 256);
      add_query(0, 0, 0);
      add_query(7, 7, 7);
      wait_idle();

      // random phases, clamped and extreme register values among them
      no_idle = 0;
      set_config(0, 0, 0, 0, 1, 2, 887);
      random_items(90);
      wait_idle();
      set_config(31, 31, 31, 31, 17, 16, 16'hFFFF);
      random_items(20);
      wait_idle();
      set_config(30, 1, 30, 16, 2, 16, 1);
      random_items(20);
      wait_idle();
      set_config(3, 2, 4, 5, 7, 2, $urandom);
      random_items(40);
      wait_idle();
      no_idle = 1;
      set_config(2, 3, 2, 16, 9, 4, 362);
      random_items(40);
      wait_idle();
      no_idle = 0;
      set_config($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                 $urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(2, 16),
                 $urandom);
      random_items(25);
      wait_idle();

      $display("covered %0d queries (%0d out of grid, %0d clipped) and %0d writes",
               n_queries, n_errs, n_sats, n_writes);
      $display("over ten register settings, with a long response stall");
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[trilinear_volume_upsampler_top.f]
rtl/tvu_pkg.sv
rtl/tvu_if.sv
rtl/trilinear_volume_upsampler_top.sv
verif/testbench.sv
